FILE: hw/rtl/grc_pkg.sv
// grc_pkg: shared types, constants and helpers of the grid region counter.
// No dependencies.
`timescale 1ns / 1ps

package grc_pkg;

   localparam int MaxSide = 128;
   localparam int SideW   = $clog2(MaxSide);
   localparam int CellW   = 2 * SideW;
   localparam int Cells   = MaxSide * MaxSide;
   localparam int CntW    = 15;
   localparam int GridW   = 8;
   localparam int ColorW  = 2;
   localparam int MarkW   = 2;
   localparam int WordW   = ColorW + MarkW;

   typedef logic [ColorW-1:0] color_type;
   typedef logic [SideW-1:0]  coord_type;
   typedef logic [CntW-1:0]   cnt_type;

   localparam color_type ColorRed   = 2'd0;
   localparam color_type ColorGreen = 2'd1;

   localparam logic [2:0] NbrUp    = 3'd0;
   localparam logic [2:0] NbrLeft  = 3'd1;
   localparam logic [2:0] NbrDown  = 3'd2;
   localparam logic [2:0] NbrRight = 3'd3;
   localparam logic [2:0] NbrDone  = 3'd4;

   typedef struct packed {
      logic      en;
      coord_type row;
      coord_type col;
      color_type color;
   } pix_wr_type;

   typedef enum logic [2:0] {
      EngIdle,
      EngScanRd,
      EngScanChk,
      EngPop,
      EngNbr,
      EngOut
   } eng_state_type;

   // red and green fold together in the merged pass
   function automatic color_type color_class(color_type c, logic merged);
      color_type r;
      r = c;
      if (merged && (c == ColorRed || c == ColorGreen)) r = ColorRed;
      return r;
   endfunction

endpackage

FILE: hw/rtl/grc_loader.sv
// grc_loader: front end. Holds grid_size, takes pixel words in raster order,
// emits grid writes and a frame job per full frame. Depends on grc_pkg.
`timescale 1ns / 1ps

module grc_loader (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [grc_pkg::GridW-1:0] csr_grid_size,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  grc_pkg::color_type       req_color,
   input  logic                     hold,
   output grc_pkg::pix_wr_type      pix_wr,
   output logic                     job_push,
   output grc_pkg::coord_type       job_side_m1
);

   logic [grc_pkg::GridW-1:0] grid_ff, grid_in;
   grc_pkg::coord_type        row_ff, row_in, col_ff, col_in;
   grc_pkg::coord_type        side_m1;
   logic                      accept;

   assign csr_ready = 1'b1;
   assign req_stall = hold;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (grid_ff == '0) begin
         side_m1 = '0;
      end else if (grid_ff > grc_pkg::GridW'(grc_pkg::MaxSide)) begin
         side_m1 = grc_pkg::SideW'(grc_pkg::MaxSide - 1);
      end else begin
         side_m1 = grc_pkg::SideW'(grid_ff - 1'b1);
      end
   end

   always_comb begin
      grid_in  = grid_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      job_push = 1'b0;
      if (csr_valid && csr_ready) begin
         grid_in = csr_grid_size;
         row_in  = '0;
         col_in  = '0;
      end else if (accept) begin
         if (col_ff == side_m1) begin
            col_in = '0;
            if (row_ff == side_m1) begin
               row_in   = '0;
               job_push = 1'b1;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   assign pix_wr.en    = accept;
   assign pix_wr.row   = row_ff;
   assign pix_wr.col   = col_ff;
   assign pix_wr.color = req_color;
   assign job_side_m1  = side_m1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff <= grc_pkg::GridW'(1);
         row_ff  <= '0;
         col_ff  <= '0;
      end else begin
         grid_ff <= grid_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
      end
   end

endmodule

FILE: hw/rtl/grc_job_fifo.sv
// grc_job_fifo: two-entry queue of frame jobs (grid side) between the
// loader and the fill engine. Depends on grc_pkg.
`timescale 1ns / 1ps

module grc_job_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  grc_pkg::coord_type push_side_m1,
   input  logic               pop,
   output logic               not_empty,
   output grc_pkg::coord_type head_side_m1
);

   grc_pkg::coord_type ent_ff [2];
   grc_pkg::coord_type ent_in [2];
   logic               wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               do_push, do_pop;

   assign do_push      = push && (count_ff != 2'd2);
   assign do_pop       = pop && (count_ff != 2'd0);
   assign not_empty    = count_ff != 2'd0;
   assign head_side_m1 = ent_ff[rd_ptr_ff];

   always_comb begin
      ent_in    = ent_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         ent_in[wr_ptr_ff] = push_side_m1;
         wr_ptr_in         = !wr_ptr_ff;
      end
      if (do_pop) rd_ptr_in = !rd_ptr_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hw/rtl/grc_fill_engine.sv
// grc_fill_engine: back end. Owns the grid memory (color plus two marks) and
// the fill queue, runs both flood-fill counts and holds the result word.
// Depends on grc_pkg.
`timescale 1ns / 1ps

module grc_fill_engine (
   input  logic                clock,
   input  logic                reset,
   input  grc_pkg::pix_wr_type pix_wr,
   input  logic                job_valid,
   input  grc_pkg::coord_type  job_side_m1,
   output logic                job_pop,
   output logic                busy,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output grc_pkg::cnt_type    rsp_normal_regions,
   output grc_pkg::cnt_type    rsp_merged_regions
);

   logic [grc_pkg::WordW-1:0] grid_mem [grc_pkg::Cells];
   logic [grc_pkg::CellW-1:0] q_mem    [grc_pkg::Cells];

   grc_pkg::eng_state_type state_ff, state_in;

   grc_pkg::coord_type        side_ff, side_in, sr_ff, sr_in, sc_ff, sc_in;
   grc_pkg::coord_type        pr_ff, pr_in, pc_ff, pc_in;
   grc_pkg::cnt_type          norm_ff, norm_in, merg_ff, merg_in;
   grc_pkg::color_type        want_ff, want_in;
   logic [grc_pkg::CellW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [2:0]                k_ff, k_in;
   logic                      pass_ff, pass_in, pend_ff, pend_in;

   logic [grc_pkg::WordW-1:0] rd_data_ff;
   logic [grc_pkg::CellW-1:0] q_rd_data_ff;

   logic                      g_rd_en, g_wr_en, q_rd_en, q_wr_en;
   logic [grc_pkg::CellW-1:0] g_rd_addr, g_wr_addr, q_wr_data, q_wr_addr;
   logic [grc_pkg::WordW-1:0] g_wr_data;

   logic                      rsp_valid_ff, rsp_valid_in, out_load;
   grc_pkg::cnt_type          rsp_norm_ff, rsp_merg_ff;

   grc_pkg::coord_type        cr, cc, nr, nc;
   logic                      nb_ok, marked, same_class, scan_last, q_empty;
   logic [grc_pkg::MarkW-1:0] mark_bit;

   assign cr         = q_rd_data_ff[grc_pkg::CellW-1 -: grc_pkg::SideW];
   assign cc         = q_rd_data_ff[grc_pkg::SideW-1:0];
   assign mark_bit   = pass_ff ? 2'b10 : 2'b01;
   assign marked     = (rd_data_ff[grc_pkg::WordW-1 -: grc_pkg::MarkW] & mark_bit) != '0;
   assign same_class = grc_pkg::color_class(rd_data_ff[grc_pkg::ColorW-1:0], pass_ff)
                       == want_ff;
   assign scan_last  = (sr_ff == side_ff) && (sc_ff == side_ff);
   assign q_empty    = head_ff == tail_ff;
   assign out_load   = (state_ff == grc_pkg::EngOut) && (!rsp_valid_ff || !rsp_stall);
   assign busy       = state_ff != grc_pkg::EngIdle;
   assign job_pop    = (state_ff == grc_pkg::EngIdle) && job_valid;

   always_comb begin
      nb_ok = 1'b0;
      nr    = cr;
      nc    = cc;
      case (k_ff)
         grc_pkg::NbrUp: begin
            nb_ok = cr != '0;
            nr    = cr - 1'b1;
         end
         grc_pkg::NbrLeft: begin
            nb_ok = cc != '0;
            nc    = cc - 1'b1;
         end
         grc_pkg::NbrDown: begin
            nb_ok = cr != side_ff;
            nr    = cr + 1'b1;
         end
         grc_pkg::NbrRight: begin
            nb_ok = cc != side_ff;
            nc    = cc + 1'b1;
         end
         default: nb_ok = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         grc_pkg::EngIdle:    if (job_valid) state_in = grc_pkg::EngScanRd;
         grc_pkg::EngScanRd:  state_in = grc_pkg::EngScanChk;
         grc_pkg::EngScanChk: begin
            if (!marked) state_in = grc_pkg::EngPop;
            else if (scan_last && pass_ff) state_in = grc_pkg::EngOut;
            else state_in = grc_pkg::EngScanRd;
         end
         grc_pkg::EngPop: begin
            if (!q_empty) state_in = grc_pkg::EngNbr;
            else if (scan_last && pass_ff) state_in = grc_pkg::EngOut;
            else state_in = grc_pkg::EngScanRd;
         end
         grc_pkg::EngNbr:     if (k_ff == grc_pkg::NbrDone) state_in = grc_pkg::EngPop;
         grc_pkg::EngOut:     if (out_load) state_in = grc_pkg::EngIdle;
         default:             state_in = grc_pkg::EngIdle;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      side_in   = side_ff;
      sr_in     = sr_ff;
      sc_in     = sc_ff;
      pr_in     = pr_ff;
      pc_in     = pc_ff;
      norm_in   = norm_ff;
      merg_in   = merg_ff;
      want_in   = want_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      k_in      = k_ff;
      pass_in   = pass_ff;
      pend_in   = 1'b0;
      g_rd_en   = 1'b0;
      g_rd_addr = {sr_ff, sc_ff};
      g_wr_en   = 1'b0;
      g_wr_addr = {pix_wr.row, pix_wr.col};
      g_wr_data = {{grc_pkg::MarkW{1'b0}}, pix_wr.color};
      q_rd_en   = 1'b0;
      q_wr_en   = 1'b0;
      q_wr_addr = tail_ff;
      q_wr_data = {sr_ff, sc_ff};
      unique case (state_ff)
         grc_pkg::EngIdle: begin
            g_wr_en = pix_wr.en;
            if (job_valid) begin
               side_in = job_side_m1;
               sr_in   = '0;
               sc_in   = '0;
               pass_in = 1'b0;
               norm_in = '0;
               merg_in = '0;
            end
         end
         grc_pkg::EngScanRd: g_rd_en = 1'b1;
         grc_pkg::EngScanChk: begin
            if (!marked) begin
               g_wr_en   = 1'b1;
               g_wr_addr = {sr_ff, sc_ff};
               g_wr_data = rd_data_ff | {mark_bit, {grc_pkg::ColorW{1'b0}}};
               q_wr_en   = 1'b1;
               q_wr_addr = '0;
               head_in   = '0;
               tail_in   = grc_pkg::CellW'(1);
               want_in   = grc_pkg::color_class(rd_data_ff[grc_pkg::ColorW-1:0], pass_ff);
               if (pass_ff) merg_in = merg_ff + 1'b1;
               else norm_in = norm_ff + 1'b1;
            end
         end
         grc_pkg::EngPop: begin
            if (!q_empty) begin
               q_rd_en = 1'b1;
               head_in = head_ff + 1'b1;
               k_in    = grc_pkg::NbrUp;
            end
         end
         grc_pkg::EngNbr: begin
            if (pend_ff && !marked && same_class) begin
               g_wr_en   = 1'b1;
               g_wr_addr = {pr_ff, pc_ff};
               g_wr_data = rd_data_ff | {mark_bit, {grc_pkg::ColorW{1'b0}}};
               q_wr_en   = 1'b1;
               q_wr_data = {pr_ff, pc_ff};
               tail_in   = tail_ff + 1'b1;
            end
            if (k_ff != grc_pkg::NbrDone) begin
               k_in = k_ff + 1'b1;
               if (nb_ok) begin
                  g_rd_en   = 1'b1;
                  g_rd_addr = {nr, nc};
                  pend_in   = 1'b1;
                  pr_in     = nr;
                  pc_in     = nc;
               end
            end
         end
         grc_pkg::EngOut: ;
         default: ;
      endcase
      // step the raster scan once a cell needs no fill or its fill is done
      if ((state_ff == grc_pkg::EngScanChk && marked) ||
          (state_ff == grc_pkg::EngPop && q_empty)) begin
         if (scan_last) begin
            sr_in   = '0;
            sc_in   = '0;
            pass_in = 1'b1;
         end else if (sc_ff == side_ff) begin
            sc_in = '0;
            sr_in = sr_ff + 1'b1;
         end else begin
            sc_in = sc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (g_wr_en) grid_mem[g_wr_addr] <= g_wr_data;
      if (g_rd_en) rd_data_ff <= grid_mem[g_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (q_wr_en) q_mem[q_wr_addr] <= q_wr_data;
      if (q_rd_en) q_rd_data_ff <= q_mem[head_ff];
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      side_ff <= side_in;
      sr_ff   <= sr_in;
      sc_ff   <= sc_in;
      pr_ff   <= pr_in;
      pc_ff   <= pc_in;
      norm_ff <= norm_in;
      merg_ff <= merg_in;
      want_ff <= want_in;
      head_ff <= head_in;
      tail_ff <= tail_in;
      k_ff    <= k_in;
      pass_ff <= pass_in;
      if (out_load) begin
         rsp_norm_ff <= norm_ff;
         rsp_merg_ff <= merg_ff;
      end
      if (reset) begin
         state_ff     <= grc_pkg::EngIdle;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_normal_regions = rsp_norm_ff;
   assign rsp_merged_regions = rsp_merg_ff;

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      pix_wr.en |-> state_ff == grc_pkg::EngIdle)
      else $error("pixel write while engine busy");

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff)
      else $error("result word lost");

   a_merge_fewer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_merg_ff <= rsp_norm_ff)
      else $error("merged count above normal count");

   a_pend_in_nbr: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == grc_pkg::EngNbr)
      else $error("neighbor check outside neighbor walk");

endmodule

FILE: hw/rtl/grid_region_counter.sv
// grid_region_counter: top level. Ties loader, job queue and fill engine.
// Depends on grc_pkg, grc_loader, grc_job_fifo, grc_fill_engine.
`timescale 1ns / 1ps

// Pixels of a frame stream in at one word per cycle in raster order; after
// the last pixel the input stalls while the engine counts 4-connected regions
// twice (all colors distinct, then red and green merged) and returns one word
// with both counts. Each count is a raster scan with a read state and a check
// state per cell plus a breadth-first fill of one queue pop, four neighbor
// reads and one drain per filled cell, the reads sharing the single read port
// of the grid memory.
// A grid_size write restarts the current frame; 0 acts as 1, values above 128
// act as 128.
module grid_region_counter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [grc_pkg::GridW-1:0] csr_grid_size,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_color,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [14:0]               rsp_normal_regions,
   output logic [14:0]               rsp_merged_regions
);

   grc_pkg::pix_wr_type pix_wr;
   grc_pkg::coord_type  push_side_m1, head_side_m1;
   logic                job_push, job_pop, job_valid, busy, hold;

   assign hold = job_valid || busy;

   grc_loader u_loader (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_grid_size (csr_grid_size),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_color     (req_color),
      .hold          (hold),
      .pix_wr        (pix_wr),
      .job_push      (job_push),
      .job_side_m1   (push_side_m1)
   );

   grc_job_fifo u_job_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (job_push),
      .push_side_m1 (push_side_m1),
      .pop          (job_pop),
      .not_empty    (job_valid),
      .head_side_m1 (head_side_m1)
   );

   grc_fill_engine u_engine (
      .clock              (clock),
      .reset              (reset),
      .pix_wr             (pix_wr),
      .job_valid          (job_valid),
      .job_side_m1        (head_side_m1),
      .job_pop            (job_pop),
      .busy               (busy),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_normal_regions (rsp_normal_regions),
      .rsp_merged_regions (rsp_merged_regions)
   );

endmodule

FILE: test/grid_region_counter_tb.sv
// grid_region_counter_tb: self-checking bench for the grid region counter.
// Streams pixel frames and checks both region counts against a flood-fill model.
// Depends on grc_pkg and grid_region_counter.
`timescale 1ns / 1ps

module grid_region_counter_tb;

   localparam grc_pkg::color_type ColorBlue   = 2'd2;
   localparam grc_pkg::color_type ColorFourth = 2'd3;
   localparam int                 CycleLimit  = 3_000_000;
   localparam int                 DrainCycles = 64;

   typedef struct {
      grc_pkg::cnt_type normal;
      grc_pkg::cnt_type merged;
   } counts_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [grc_pkg::GridW-1:0] csr_grid_size;
   logic                      req_valid;
   logic                      req_stall;
   logic [1:0]                req_color;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [14:0]               rsp_normal_regions;
   logic [14:0]               rsp_merged_regions;

   grid_region_counter DUT (.*);

   // frame model
   grc_pkg::color_type frame_px [0:grc_pkg::Cells-1];
   bit                 seen [0:grc_pkg::Cells-1];
   int                 fill_q[$];
   int                 side_reg;
   int                 px_count;
   counts_type         counts_q[$];
   int                 err_count = 0;
   int                 cycle_count = 0;
   bit                 no_gaps;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic grc_pkg::color_type region_class(grc_pkg::color_type c, bit merged);
      return (merged && c <= grc_pkg::ColorGreen) ? grc_pkg::ColorRed : c;
   endfunction

   function automatic int count_regions(int side, bit merged);
      int n, cur, r, c, nb;
      grc_pkg::color_type want;
      n = 0;
      for (int i = 0; i < side * side; i++) seen[i] = 1'b0;
      for (int i = 0; i < side * side; i++) begin
         if (!seen[i]) begin
            n++;
            want = region_class(frame_px[i], merged);
            seen[i] = 1'b1;
            fill_q.delete();
            fill_q.push_back(i);
            while (fill_q.size() > 0) begin
               cur = fill_q.pop_front();
               r = cur / side;
               c = cur % side;
               for (int d = 0; d < 4; d++) begin
                  nb = -1;
                  case (d)
                     0: if (r > 0) nb = cur - side;
                     1: if (c > 0) nb = cur - 1;
                     2: if (r + 1 < side) nb = cur + side;
                     default: if (c + 1 < side) nb = cur + 1;
                  endcase
                  if (nb >= 0 && !seen[nb] && region_class(frame_px[nb], merged) == want) begin
                     seen[nb] = 1'b1;
                     fill_q.push_back(nb);
                  end
               end
            end
         end
      end
      return n;
   endfunction

   function automatic void predict_pixel(grc_pkg::color_type c);
      int side;
      counts_type e;
      side = (side_reg == 0) ? 1 :
             (side_reg > grc_pkg::MaxSide ? grc_pkg::MaxSide : side_reg);
      if (px_count >= side * side) px_count = 0;
      frame_px[px_count] = c;
      px_count++;
      if (px_count < side * side) return;
      px_count = 0;
      e.normal = grc_pkg::cnt_type'(count_regions(side, 1'b0));
      e.merged = grc_pkg::cnt_type'(count_regions(side, 1'b1));
      counts_q.push_back(e);
   endfunction

   function automatic bit gap_now();
      return !no_gaps && ($urandom_range(99) < 36);
   endfunction

   task automatic send_pixel(grc_pkg::color_type c);
      while (gap_now()) begin
         req_valid <= 1'b0;
         req_color <= 2'($urandom);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_color <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_pixel(c);
   endtask

   task automatic write_grid_size(logic [grc_pkg::GridW-1:0] v);
      req_valid <= 1'b0;
      @(posedge clock);
      while (counts_q.size() > 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      csr_valid     <= 1'b1;
      csr_grid_size <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      side_reg  = v;
      px_count  = 0;
   endtask

   task automatic send_frame(int side, int palette);
      for (int i = 0; i < side * side; i++)
         send_pixel(grc_pkg::color_type'($urandom_range(palette)));
   endtask

   task automatic test_directed();
      grc_pkg::color_type pat [16] = '{
         grc_pkg::ColorRed, grc_pkg::ColorRed, grc_pkg::ColorRed, grc_pkg::ColorRed,
         grc_pkg::ColorRed, grc_pkg::ColorGreen, grc_pkg::ColorGreen, grc_pkg::ColorRed,
         ColorFourth, ColorFourth, ColorFourth, ColorFourth,
         ColorBlue, grc_pkg::ColorRed, grc_pkg::ColorGreen, ColorFourth};
      write_grid_size(8'd0);
      send_pixel(grc_pkg::ColorRed);
      send_pixel(grc_pkg::ColorGreen);
      send_pixel(ColorBlue);
      send_pixel(ColorFourth);
      write_grid_size(8'd2);
      foreach (pat[i]) send_pixel(pat[i]);
   endtask

   // register extremes; each later write drops the partial frame before it
   task automatic test_restart();
      write_grid_size(8'd255);
      repeat (5) send_pixel(ColorBlue);
      write_grid_size(8'd128);
      repeat (3) send_pixel(grc_pkg::ColorGreen);
      write_grid_size(8'd3);
      repeat (4) send_pixel(ColorFourth);
      write_grid_size(8'd3);
      send_frame(3, 3);
   endtask

   task automatic test_random();
      int side, sent;
      sent = 0;
      no_gaps = 1'b1;
      while (sent < 780) begin
         if (sent > 300) no_gaps = 1'b0;
         side = ($urandom_range(9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
         write_grid_size(8'(side));
         repeat ($urandom_range(1, 3)) begin
            send_frame(side, $urandom_range(1, 3));
            sent += side * side;
         end
         if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, side * side))
               send_pixel(grc_pkg::color_type'($urandom));
         end
      end
   endtask

   task automatic test_large_grid();
      write_grid_size(8'd20);
      send_frame(20, 3);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("grid_region_counter_tb: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (counts_q.size() == 0) begin
               err_count++;
               if (err_count <= 10) $display("unexpected word: normal %0d merged %0d",
                                             rsp_normal_regions, rsp_merged_regions);
            end else begin
               counts_type e;
               e = counts_q.pop_front();
               if (rsp_normal_regions !== e.normal || rsp_merged_regions !== e.merged) begin
                  err_count++;
                  if (err_count <= 10)
                     $display("mismatch: normal exp %0d got %0d, merged exp %0d got %0d",
                              e.normal, rsp_normal_regions, e.merged, rsp_merged_regions);
               end
            end
         end
         rsp_stall <= gap_now();
      end
   end

   initial begin
      reset         = 1'b1;
      csr_valid     = 1'b0;
      csr_grid_size = '0;
      req_valid     = 1'b0;
      req_color     = '0;
      no_gaps       = 1'b0;
      side_reg      = 1;
      px_count      = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_restart();
      test_random();
      test_large_grid();
      req_valid <= 1'b0;
      @(posedge clock);
      while (counts_q.size() > 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (err_count == 0) begin
         $display("grid_region_counter_tb: done, clean");
      end else begin
         $display("grid_region_counter_tb: done, errors");
      end
      $finish;
   end

endmodule
